>>> design/midi_pad_gate_router_top_assert.svh
// Assertion macros for the MIDI pad gate router checker.
// No dependencies; included by the checker file.
`ifndef MIDI_PAD_GATE_ROUTER_TOP_ASSERT_SVH
`define MIDI_PAD_GATE_ROUTER_TOP_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define MPGR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// clocked assertion that also holds across reset
`define MPGR_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`endif

>>> design/mpgr_pkg.sv
// Package for the MIDI pad gate router: payload structs, codes, constants.
// No dependencies; used by every module of the block.
package mpgr_pkg;

    localparam int COUNT_WIDTH_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_IS_MASTER   = 3'd0;
    localparam logic [2:0] REG_PAD_NOTE    = 3'd1;
    localparam logic [2:0] REG_CTRL_CHAN   = 3'd2;
    localparam logic [2:0] REG_MOD_WHEEL   = 3'd3;
    localparam logic [2:0] REG_FIRST_SLD   = 3'd4;
    localparam logic [2:0] REG_FIRST_KNOB  = 3'd5;

    // status nibbles
    localparam logic [3:0] MODE_NOTE_OFF   = 4'd8;
    localparam logic [3:0] MODE_NOTE_ON    = 4'd9;
    localparam logic [3:0] MODE_KEY_PRESS  = 4'd10;
    localparam logic [3:0] MODE_CTRL_CHG   = 4'd11;
    localparam logic [3:0] MODE_PITCH_BEND = 4'd14;

    // event kinds
    localparam logic [3:0] KIND_GATE_OPEN  = 4'd0;
    localparam logic [3:0] KIND_GATE_CLOSE = 4'd1;
    localparam logic [3:0] KIND_NOTE_ON    = 4'd2;
    localparam logic [3:0] KIND_NOTE_OFF   = 4'd3;
    localparam logic [3:0] KIND_AFTERTOUCH = 4'd4;
    localparam logic [3:0] KIND_BEND       = 4'd5;
    localparam logic [3:0] KIND_MODWHEEL   = 4'd6;
    localparam logic [3:0] KIND_KNOB       = 4'd7;
    localparam logic [3:0] KIND_SLIDER     = 4'd8;

    // last offset of the slider and knob controller ranges
    localparam logic [7:0] SLIDER_SPAN_LAST = 8'd3;
    localparam logic [7:0] KNOB_SPAN_LAST   = 8'd7;

    // reset values of the registers
    localparam logic       RST_IS_MASTER  = 1'b1;
    localparam logic [6:0] RST_PAD_NOTE   = 7'd36;
    localparam logic [3:0] RST_CTRL_CHAN  = 4'd9;
    localparam logic [6:0] RST_MOD_WHEEL  = 7'd1;
    localparam logic [6:0] RST_FIRST_SLD  = 7'd82;
    localparam logic [6:0] RST_FIRST_KNOB = 7'd74;

    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] channel;
        logic [6:0] data_first;
        logic [6:0] data_second;
    } t_in_item;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [6:0] event_index;
        logic [6:0] event_value;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       is_master;
        logic [6:0] pad_note;
        logic [3:0] control_channel;
        logic [6:0] mod_wheel_cc;
        logic [6:0] first_slider_cc;
        logic [6:0] first_knob_cc;
    } t_cfg;

    // one classified item: optional gate edge, then optional routed event
    typedef struct packed {
        logic       has_gate;
        logic       gate_open;
        logic       has_evt;
        logic [3:0] kind;
        logic [6:0] index;
        logic [6:0] value;
    } t_cmd;

endpackage

>>> design/mpgr_cfg.sv
// Configuration register file of the MIDI pad gate router, APB-style port.
// Depends on mpgr_pkg.
module mpgr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpgr_pkg::PADDR_W-1:0] paddr,
    input  logic [mpgr_pkg::PDATA_W-1:0] pwdata,
    output logic [mpgr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output mpgr_pkg::t_cfg              o_cfg
);
    import mpgr_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_master       <= RST_IS_MASTER;
            r_cfg.pad_note        <= RST_PAD_NOTE;
            r_cfg.control_channel <= RST_CTRL_CHAN;
            r_cfg.mod_wheel_cc    <= RST_MOD_WHEEL;
            r_cfg.first_slider_cc <= RST_FIRST_SLD;
            r_cfg.first_knob_cc   <= RST_FIRST_KNOB;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_IS_MASTER:  r_cfg.is_master       <= pwdata[0];
                REG_PAD_NOTE:   r_cfg.pad_note        <= pwdata[6:0];
                REG_CTRL_CHAN:  r_cfg.control_channel <= pwdata[3:0];
                REG_MOD_WHEEL:  r_cfg.mod_wheel_cc    <= pwdata[6:0];
                REG_FIRST_SLD:  r_cfg.first_slider_cc <= pwdata[6:0];
                REG_FIRST_KNOB: r_cfg.first_knob_cc   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_IS_MASTER:  prdata[0]   = r_cfg.is_master;
            REG_PAD_NOTE:   prdata[6:0] = r_cfg.pad_note;
            REG_CTRL_CHAN:  prdata[3:0] = r_cfg.control_channel;
            REG_MOD_WHEEL:  prdata[6:0] = r_cfg.mod_wheel_cc;
            REG_FIRST_SLD:  prdata[6:0] = r_cfg.first_slider_cc;
            REG_FIRST_KNOB: prdata[6:0] = r_cfg.first_knob_cc;
            default: ;
        endcase
    end

endmodule

>>> design/mpgr_front.sv
// Front end: classifies each accepted message, tracks gate and held pads,
// and produces at most one command for the queue. Depends on mpgr_pkg.
module mpgr_front #(
    parameter int COUNT_WIDTH = mpgr_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpgr_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  mpgr_pkg::t_in_item i_item,
    output logic               o_cmd_valid,
    output mpgr_pkg::t_cmd     o_cmd
);
    import mpgr_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_gate;
    logic                   n_gate;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic                   on_ctrl;
    logic                   pad_hit;
    logic                   note_on;
    logic                   in_slider;
    logic                   in_knob;
    logic [7:0]             d1_ext;
    logic [7:0]             sld_ext;
    logic [7:0]             knob_ext;
    t_cmd                   cmd;

    assign on_ctrl   = (i_item.channel == i_cfg.control_channel);
    assign pad_hit   = (i_item.data_first == i_cfg.pad_note);
    assign note_on   = (i_item.mode == MODE_NOTE_ON);
    assign count_dec = (r_count != '0) ? r_count - 1'b1 : r_count;
    assign d1_ext    = {1'b0, i_item.data_first};
    assign sld_ext   = {1'b0, i_cfg.first_slider_cc};
    assign knob_ext  = {1'b0, i_cfg.first_knob_cc};
    assign in_slider = (d1_ext >= sld_ext) && (d1_ext <= sld_ext + SLIDER_SPAN_LAST);
    assign in_knob   = (d1_ext >= knob_ext) && (d1_ext <= knob_ext + KNOB_SPAN_LAST);

    always_comb begin
        n_gate  = r_gate;
        n_count = r_count;
        cmd     = '0;
        unique case (i_item.mode) inside
            MODE_NOTE_OFF, MODE_NOTE_ON: begin
                if (!on_ctrl) begin
                    if (i_cfg.is_master) begin
                        cmd.has_evt = 1'b1;
                        cmd.kind    = note_on ? KIND_NOTE_ON : KIND_NOTE_OFF;
                        cmd.index   = i_item.data_first;
                        cmd.value   = note_on ? i_item.data_second : 7'd0;
                    end
                end else if (i_cfg.is_master) begin
                    if (note_on) begin
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                        if (r_gate) begin
                            n_gate        = 1'b0;
                            cmd.has_gate  = 1'b1;
                            cmd.gate_open = 1'b0;
                        end
                    end else begin
                        n_count = count_dec;
                        if (count_dec == '0 && !r_gate) begin
                            n_gate        = 1'b1;
                            cmd.has_gate  = 1'b1;
                            cmd.gate_open = 1'b1;
                        end
                    end
                end else if (pad_hit) begin
                    if (r_gate != note_on) begin
                        n_gate        = note_on;
                        cmd.has_gate  = 1'b1;
                        cmd.gate_open = note_on;
                    end
                    cmd.has_evt = 1'b1;
                    cmd.kind    = note_on ? KIND_NOTE_ON : KIND_NOTE_OFF;
                    cmd.index   = i_item.data_first;
                    cmd.value   = note_on ? i_item.data_second : 7'd0;
                end
            end
            MODE_KEY_PRESS: begin
                if (on_ctrl && pad_hit) begin
                    cmd.has_evt = 1'b1;
                    cmd.kind    = KIND_AFTERTOUCH;
                    cmd.index   = i_item.data_first;
                    cmd.value   = i_item.data_second;
                end
            end
            MODE_PITCH_BEND: begin
                cmd.has_evt = r_gate;
                cmd.kind    = KIND_BEND;
                cmd.value   = i_item.data_second;
            end
            MODE_CTRL_CHG: begin
                cmd.value = i_item.data_second;
                // mod wheel beats slider, slider beats knob
                if (i_item.data_first == i_cfg.mod_wheel_cc) begin
                    cmd.has_evt = r_gate;
                    cmd.kind    = KIND_MODWHEEL;
                end else if (in_slider) begin
                    cmd.has_evt = 1'b1;
                    cmd.kind    = KIND_SLIDER;
                    cmd.index   = i_item.data_first - i_cfg.first_slider_cc;
                end else if (in_knob) begin
                    cmd.has_evt = r_gate;
                    cmd.kind    = KIND_KNOB;
                    cmd.index   = i_item.data_first - i_cfg.first_knob_cc;
                end
            end
            default: ;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = i_accept && (cmd.has_gate || cmd.has_evt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= 1'b1;
            r_count <= '0;
        end else if (i_accept) begin
            r_gate  <= n_gate;
            r_count <= n_count;
        end
    end

endmodule

>>> design/mpgr_queue.sv
// Short command queue between front and back end of the router.
// Depends on mpgr_pkg.
module mpgr_queue #(
    parameter int DEPTH = mpgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpgr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mpgr_pkg::t_cmd o_head
);
    import mpgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
        end
    end

endmodule

>>> design/mpgr_back.sv
// Back end: expands each queued command into its gate edge and routed event,
// one result per cycle if popped, via an output register. Depends on mpgr_pkg.
module mpgr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  mpgr_pkg::t_cmd      i_head,
    output logic                o_deq,
    input  logic                i_pop,
    output logic                o_empty,
    output mpgr_pkg::t_out_item o_result
);
    import mpgr_pkg::*;

    logic      r_out_valid;
    logic      r_phase;      // gate edge of head already sent
    t_out_item r_out;
    t_out_item nxt;
    logic      out_take;
    logic      load;
    logic      gate_phase;

    assign out_take   = r_out_valid && i_pop;
    assign load       = i_head_valid && (!r_out_valid || out_take);
    assign gate_phase = !r_phase && i_head.has_gate;
    assign o_deq      = load && !(gate_phase && i_head.has_evt);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        if (gate_phase) begin
            nxt.event_kind  = i_head.gate_open ? KIND_GATE_OPEN : KIND_GATE_CLOSE;
            nxt.event_index = 7'd0;
            nxt.event_value = 7'd0;
            nxt.last        = !i_head.has_evt;
        end else begin
            nxt.event_kind  = i_head.kind;
            nxt.event_index = i_head.index;
            nxt.event_value = i_head.value;
            nxt.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_phase     <= gate_phase && i_head.has_evt;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/midi_pad_gate_router_top.sv
// An accepted message's command goes into the command queue, then into the
// output register once free. Throughput: one message per cycle in unless full,
// one result per cycle out while pop is high; a message that flips the gate and
// routes an event gives two results, and the command queue absorbs such bursts.
// Reset (synchronous, active low) empties queue and output, opens the gate,
// clears the held-pad count and loads register defaults.
module midi_pad_gate_router_top #(
    parameter int COUNT_WIDTH = mpgr_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = mpgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpgr_pkg::PADDR_W-1:0] paddr,
    input  logic [mpgr_pkg::PDATA_W-1:0] pwdata,
    output logic [mpgr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  mpgr_pkg::t_in_item           i_item,
    output logic                         empty,
    input  logic                         pop,
    output mpgr_pkg::t_out_item          o_result
);
    import mpgr_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_cmd head;
    logic accept;
    logic cmd_valid;
    logic head_valid;
    logic deq;

    assign accept = push && !full;

    mpgr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mpgr_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    mpgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (deq),
        .o_valid (head_valid),
        .o_head  (head)
    );

    mpgr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_deq        (deq),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

>>> design/mpgr_checker.sv
// Port-level checks for the MIDI pad gate router, bound to the top level.
// Depends on mpgr_pkg and midi_pad_gate_router_top_assert.svh.
`include "midi_pad_gate_router_top_assert.svh"

module mpgr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input mpgr_pkg::t_out_item o_result
);
    import mpgr_pkg::*;

    logic is_gate_evt;
    logic gate_fields_zero;

    assign is_gate_evt = (o_result.event_kind == KIND_GATE_OPEN) ||
                         (o_result.event_kind == KIND_GATE_CLOSE);
    assign gate_fields_zero = (o_result.event_index == 7'd0) &&
                              (o_result.event_value == 7'd0);

    `MPGR_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> empty && !full)
    `MPGR_ASSERT(a_result_holds, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_result))
    `MPGR_ASSERT(a_kind_range, i_clk, i_rst_n, !empty |-> o_result.event_kind <= KIND_SLIDER)
    `MPGR_ASSERT(a_gate_fields, i_clk, i_rst_n, !empty && is_gate_evt |-> gate_fields_zero)
    `MPGR_ASSERT(a_second_follows, i_clk, i_rst_n, !empty && pop && !o_result.last |=> !empty)

endmodule

bind midi_pad_gate_router_top mpgr_checker u_mpgr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

>>> verif/tb_midi_pad_gate_router_top.sv
// Testbench for midi_pad_gate_router_top: push/pop queue ports plus APB register writes,
// with a scoreboard that predicts the routed event stream. Depends on mpgr_pkg
// and the design files.
module tb_midi_pad_gate_router_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpgr_pkg::*;

    localparam int COUNT_W = COUNT_WIDTH_DEF;
    // status nibbles the block does not route
    localparam logic [3:0] MODE_UNUSED_LOW  = 4'd0;
    localparam logic [3:0] MODE_UNUSED_HIGH = 4'd15;

    // predicts routed events per accepted message and checks them in order
    class gate_router_scoreboard;
        t_cfg               cfg;
        bit                 gate_open;
        logic [COUNT_W-1:0] held_pads;
        t_out_item          pending[$];
        t_out_item          batch[$];
        int                 errors;

        function new();
            cfg.is_master       = RST_IS_MASTER;
            cfg.pad_note        = RST_PAD_NOTE;
            cfg.control_channel = RST_CTRL_CHAN;
            cfg.mod_wheel_cc    = RST_MOD_WHEEL;
            cfg.first_slider_cc = RST_FIRST_SLD;
            cfg.first_knob_cc   = RST_FIRST_KNOB;
            gate_open = 1'b1;
            held_pads = '0;
            errors    = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_IS_MASTER:  cfg.is_master       = value[0];
                REG_PAD_NOTE:   cfg.pad_note        = value[6:0];
                REG_CTRL_CHAN:  cfg.control_channel = value[3:0];
                REG_MOD_WHEEL:  cfg.mod_wheel_cc    = value[6:0];
                REG_FIRST_SLD:  cfg.first_slider_cc = value[6:0];
                REG_FIRST_KNOB: cfg.first_knob_cc   = value[6:0];
                default: ;
            endcase
        endfunction

        function void add_event(logic [3:0] kind, logic [6:0] index, logic [6:0] value);
            t_out_item ev;
            ev.event_kind  = kind;
            ev.event_index = index;
            ev.event_value = value;
            ev.last        = 1'b0;
            batch.insert(batch.size(), ev);
        endfunction

        function void set_gate(bit open);
            if (gate_open != open) begin
                gate_open = open;
                add_event(open ? KIND_GATE_OPEN : KIND_GATE_CLOSE, '0, '0);
            end
        endfunction

        function void note_message(t_in_item m);
            bit on_ctrl;
            bit note_on;
            int d1;
            int fs;
            int fk;
            logic [3:0] note_kind;
            logic [6:0] note_vel;
            on_ctrl   = (m.channel == cfg.control_channel);
            note_on   = (m.mode == MODE_NOTE_ON);
            d1        = m.data_first;
            fs        = cfg.first_slider_cc;
            fk        = cfg.first_knob_cc;
            note_kind = note_on ? KIND_NOTE_ON : KIND_NOTE_OFF;
            note_vel  = note_on ? m.data_second : 7'd0;
            batch.delete();
            case (m.mode) inside
                MODE_NOTE_ON, MODE_NOTE_OFF: begin
                    if (!on_ctrl) begin
                        if (cfg.is_master) add_event(note_kind, m.data_first, note_vel);
                    end else if (cfg.is_master) begin
                        if (note_on) begin
                            if (held_pads != {COUNT_W{1'b1}}) held_pads++;
                            set_gate(1'b0);
                        end else begin
                            if (held_pads != '0) held_pads--;
                            if (held_pads == '0) set_gate(1'b1);
                        end
                    end else if (m.data_first == cfg.pad_note) begin
                        set_gate(note_on);
                        add_event(note_kind, m.data_first, note_vel);
                    end
                end
                MODE_KEY_PRESS: begin
                    if (on_ctrl && m.data_first == cfg.pad_note)
                        add_event(KIND_AFTERTOUCH, m.data_first, m.data_second);
                end
                MODE_PITCH_BEND: begin
                    if (gate_open) add_event(KIND_BEND, '0, m.data_second);
                end
                MODE_CTRL_CHG: begin
                    // mod wheel beats slider, slider beats knob
                    if (m.data_first == cfg.mod_wheel_cc) begin
                        if (gate_open) add_event(KIND_MODWHEEL, '0, m.data_second);
                    end else if (d1 >= fs && d1 <= fs + 3) begin
                        add_event(KIND_SLIDER, 7'(d1 - fs), m.data_second);
                    end else if (d1 >= fk && d1 <= fk + 7) begin
                        if (gate_open) add_event(KIND_KNOB, 7'(d1 - fk), m.data_second);
                    end
                end
                default: ;
            endcase
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) pending.insert(pending.size(), batch[i]);
        endfunction

        function void check_event(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $error("unexpected result: kind %0d index %0d value %0d last %0d",
                       got.event_kind, got.event_index, got.event_value, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.event_kind !== want.event_kind) begin
                $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
                errors++;
            end
            if (got.event_index !== want.event_index) begin
                $error("event_index: expected %0d, got %0d", want.event_index, got.event_index);
                errors++;
            end
            if (got.event_value !== want.event_value) begin
                $error("event_value: expected %0d, got %0d", want.event_value, got.event_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                push    = 1'b0;
    logic                full;
    t_in_item            i_item  = '0;
    logic                empty;
    logic                pop     = 1'b0;
    t_out_item           o_result;

    int tx_idle_pct = 28;
    int rx_idle_pct = 57;

    gate_router_scoreboard sb = new();

    midi_pad_gate_router_top #(
        .COUNT_WIDTH(COUNT_W)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result check first: a result never belongs to a message taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) sb.check_event(o_result);
            if (push && !full) sb.note_message(i_item);
        end
    end

    function automatic t_in_item msg(logic [3:0] mode, logic [3:0] ch,
                                     logic [6:0] d1, logic [6:0] d2);
        t_in_item m;
        m.mode        = mode;
        m.channel     = ch;
        m.data_first  = d1;
        m.data_second = d2;
        return m;
    endfunction

    // mostly well-formed traffic aimed at the configured pad, channel and CC ranges
    function automatic t_in_item random_message();
        t_in_item m;
        int       r;
        int       pick;
        r    = $urandom_range(99);
        pick = $urandom_range(99);
        m    = msg(4'($urandom_range(15)), 4'($urandom_range(15)),
                   7'($urandom_range(127)), 7'($urandom_range(127)));
        if (r < 6) return m;
        if (r < 32) begin
            m.mode = $urandom_range(1) ? MODE_NOTE_ON : MODE_NOTE_OFF;
            if (pick < 55) m.channel = sb.cfg.control_channel;
            if ($urandom_range(99) < 60) m.data_first = sb.cfg.pad_note;
        end else if (r < 42) begin
            m.mode = MODE_KEY_PRESS;
            if (pick < 70) m.channel = sb.cfg.control_channel;
            if ($urandom_range(99) < 60) m.data_first = sb.cfg.pad_note;
        end else if (r < 56) begin
            m.mode = MODE_PITCH_BEND;
        end else begin
            m.mode = MODE_CTRL_CHG;
            if (pick < 25)
                m.data_first = sb.cfg.mod_wheel_cc;
            else if (pick < 55)
                m.data_first = 7'(sb.cfg.first_slider_cc + $urandom_range(3));
            else if (pick < 85)
                m.data_first = 7'(sb.cfg.first_knob_cc + $urandom_range(7));
        end
        return m;
    endfunction

    task automatic send_message(t_in_item m);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= m;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // hold off input until the output side has drained
    task automatic wait_for_results();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // leaves psel high so writes can follow back to back; caller releases the bus
    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_setting(bit master, int pad, int ch, int mod, int sld, int knob);
        write_register(REG_IS_MASTER, 32'(master));
        write_register(REG_PAD_NOTE, pad);
        write_register(REG_CTRL_CHAN, ch);
        write_register(REG_MOD_WHEEL, mod);
        write_register(REG_FIRST_SLD, sld);
        write_register(REG_FIRST_KNOB, knob);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_in_item directed[$];
        t_in_item m;
        directed = '{
            msg(MODE_NOTE_ON,     4'd0,          7'd0,   7'd127),
            msg(MODE_NOTE_OFF,    4'd15,         7'd127, 7'd127),
            msg(MODE_NOTE_ON,     RST_CTRL_CHAN, 7'd0,   7'd0),   // pad press closes gate
            msg(MODE_PITCH_BEND,  4'd3,          7'd127, 7'd64),  // gated
            msg(MODE_CTRL_CHG,    4'd0,          RST_MOD_WHEEL, 7'd5),
            msg(MODE_CTRL_CHG,    4'd0,          RST_FIRST_KNOB, 7'd9),
            msg(MODE_CTRL_CHG,    4'd1,          RST_FIRST_SLD, 7'd0),
            msg(MODE_CTRL_CHG,    4'd1,          7'(RST_FIRST_SLD + 3), 7'd127),
            msg(MODE_NOTE_ON,     RST_CTRL_CHAN, 7'd127, 7'd127),
            msg(MODE_NOTE_OFF,    RST_CTRL_CHAN, 7'd5,   7'd0),
            msg(MODE_NOTE_OFF,    RST_CTRL_CHAN, 7'd6,   7'd0),   // count to zero opens gate
            msg(MODE_NOTE_OFF,    RST_CTRL_CHAN, 7'd7,   7'd1),   // release at zero
            msg(MODE_PITCH_BEND,  4'd9,          7'd0,   7'd127),
            msg(MODE_CTRL_CHG,    4'd15,         RST_MOD_WHEEL, 7'd0),
            msg(MODE_CTRL_CHG,    4'd2,          7'(RST_FIRST_KNOB + 7), 7'd77),
            msg(MODE_CTRL_CHG,    4'd2,          7'(RST_FIRST_SLD + 4), 7'd33),
            msg(MODE_KEY_PRESS,   RST_CTRL_CHAN, RST_PAD_NOTE, 7'd127),
            msg(MODE_KEY_PRESS,   RST_CTRL_CHAN, 7'(RST_PAD_NOTE + 1), 7'd10),
            msg(MODE_KEY_PRESS,   4'd0,          RST_PAD_NOTE, 7'd10),
            msg(MODE_UNUSED_LOW,  4'd0,          7'd0,   7'd0),
            msg(MODE_UNUSED_HIGH, 4'd15,         7'd127, 7'd127),
            msg(MODE_NOTE_ON,     4'd4,          7'd60,  7'd0),   // velocity zero stays note on
            msg(MODE_NOTE_ON,     RST_CTRL_CHAN, RST_PAD_NOTE, 7'd90),
            msg(MODE_NOTE_OFF,    RST_CTRL_CHAN, RST_PAD_NOTE, 7'd90)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_message(directed[i]);

        // drive the held-pad count into saturation, then all the way back down
        for (int n = 0; n < 640; n++) begin
            if (n % 8 == 7) begin
                send_message(random_message());
            end else begin
                m = msg((n < 320) ? MODE_NOTE_ON : MODE_NOTE_OFF, sb.cfg.control_channel,
                        7'($urandom_range(127)), 7'($urandom_range(127)));
                send_message(m);
            end
        end

        for (int p = 0; p < 6; p++) begin
            wait_for_results();
            if (p == 2) begin
                tx_idle_pct = 57;
                rx_idle_pct = 28;
            end else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: apply_setting(1'b0, 0, 0, 0, 0, 0);
                1: apply_setting(1'b1, 127, 15, 127, 124, 120);
                default: apply_setting(1'(p % 2), $urandom_range(127), $urandom_range(15),
                                       $urandom_range(127), $urandom_range(124),
                                       $urandom_range(120));
            endcase
            for (int n = 0; n < 215; n++) begin
                if (n == 107) wait_for_results();
                send_message(random_message());
            end
        end

        wait_for_results();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[midi_pad_gate_router_top] OK");
        end else begin
            $display("[midi_pad_gate_router_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[midi_pad_gate_router_top] ERROR");
        $finish;
    end

endmodule

>>> midi_pad_gate_router_top.f
+incdir+design
design/mpgr_pkg.sv
design/mpgr_cfg.sv
design/mpgr_front.sv
design/mpgr_queue.sv
design/mpgr_back.sv
design/midi_pad_gate_router_top.sv
design/mpgr_checker.sv
verif/tb_midi_pad_gate_router_top.sv
